[src/msd_pkg.sv]
// msd_pkg: shared types and constants for the motion stall detector
// beat payload structs, register indexes, reset values and field widths
// used by msd_axis_unit and motion_stall_detector
`timescale 1ns / 1ps

package msd_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int TIME_W       = 32;
    localparam int ENERGY_W     = 32;
    localparam int THR_W        = 16;
    localparam int WIN_REG_W    = 8;
    // largest average magnitude is 32768, so 17 bits of quotient
    localparam int QUO_W        = 17;
    localparam int NUM_AXES     = 6;
    localparam int AXIS_W       = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int MAX_WINDOW_DEF = 255;

    localparam logic [CFG_IDX_W-1:0] CFG_STUCK_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SAMPLES  = 2'd2;

    localparam logic [THR_W-1:0]     THRESHOLD_RST = 16'd100;
    localparam logic [TIME_W-1:0]    TIMEOUT_RST   = 32'd5000;
    localparam logic [WIN_REG_W-1:0] WINDOW_RST    = 8'd10;

    // first gyro axis index, one past the last accelerometer axis
    localparam logic [AXIS_W-1:0] GYRO_FIRST = 3'd3;
    localparam logic [AXIS_W-1:0] AXIS_LAST  = 3'd5;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] gyro_x;
        logic signed [SAMPLE_W-1:0] gyro_y;
        logic signed [SAMPLE_W-1:0] gyro_z;
        logic [TIME_W-1:0]          now_ms;
    } msd_in_t;

    typedef struct packed {
        logic                stuck;
        logic [ENERGY_W-1:0] accel_energy;
        logic [ENERGY_W-1:0] gyro_energy;
    } msd_out_t;

endpackage

[src/msd_axis_unit.sv]
// msd_axis_unit: per-axis average and square, one bit per cycle
// restoring division of the sum magnitude by the window length, then shift-add squaring
// depends on msd_pkg
`timescale 1ns / 1ps

module msd_axis_unit #(
    parameter int SUM_W = 24,
    parameter int CNT_W = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [SUM_W-1:0]              mag,
    input  logic [CNT_W-1:0]              len,
    output logic                          done,
    output logic [msd_pkg::ENERGY_W-1:0]  square
);
    import msd_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQR
    } unit_state_t;

    unit_state_t         state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                done_reg;
    logic [SUM_W-1:0]    dvd_reg;
    logic [SUM_W-1:0]    dvd_next;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    rem_next;
    logic [CNT_W:0]      trial;
    logic                fits;
    logic [ENERGY_W-1:0] mcand_reg;
    logic [QUO_W-1:0]    mplier_reg;
    logic [ENERGY_W-1:0] acc_reg;

    // one quotient bit per cycle, quotient shifts in behind the dividend
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[SUM_W-1]};
        fits     = (trial >= {1'b0, len});
        rem_next = fits ? CNT_W'(trial - {1'b0, len}) : trial[CNT_W-1:0];
        dvd_next = {dvd_reg[SUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_DIV;
                        step_reg  <= '0;
                    end
                end
                ST_DIV:
                begin
                    if (step_reg == STEP_W'(SUM_W - 1))
                    begin
                        state_reg <= ST_SQR;
                        step_reg  <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_SQR:
                begin
                    if (step_reg == STEP_W'(QUO_W - 1))
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    dvd_reg <= mag;
                    rem_reg <= '0;
                end
            end
            ST_DIV:
            begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    mcand_reg  <= ENERGY_W'(dvd_next[QUO_W-1:0]);
                    mplier_reg <= dvd_next[QUO_W-1:0];
                    acc_reg    <= '0;
                end
            end
            ST_SQR:
            begin
                if (mplier_reg[0])
                begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= {mcand_reg[ENERGY_W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[QUO_W-1:1]};
            end
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign square = acc_reg;

endmodule

[src/motion_stall_detector.sv]
// motion_stall_detector: windowed six-axis stillness check with a stuck timeout
// top level; bit-serial window sums, uses msd_axis_unit and msd_pkg
//
// usage: samples come in on in_valid/in_stall with in_data; a beat is taken when
// in_valid is high and in_stall low. results leave on out_valid/out_stall.
// only the sample that closes a window gives a result beat: stuck flag plus the
// accelerometer and gyro energies of the window averages.
// for a sample that does not close a window, the six running sums are added one
// bit per cycle through 24-bit shift registers (SUM_W bits). a closing sample
// then runs the six axes through one shared divide-and-square unit (SUM_W divide
// steps, 17 square steps, load and hand-off each) until the result is registered.
// in_stall is high for all of that time; one sample is in flight at a time.
// the result sits in an output register: a stalled receiver holds it, and the
// block goes on taking samples; only a second finished window waits for it.
// configuration is written through cfg_we/cfg_index/cfg_data while idle; the
// user must keep to this, the block itself does not enforce it.
// reset (rst_n, asynchronous) empties the window, clears the last-motion time and
// restores threshold 100, timeout 5000 ms and window length 10.
`timescale 1ns / 1ps

module motion_stall_detector #(
    parameter int MAX_WINDOW = msd_pkg::MAX_WINDOW_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  msd_pkg::msd_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output msd_pkg::msd_out_t               out_data,
    input  logic                            cfg_we,
    input  logic [msd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import msd_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_CLOSE_LOAD,
        ST_CLOSE_WAIT,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [STEP_W-1:0]      bit_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_inc;
    logic                   fresh_reg;
    logic [AXIS_W-1:0]      axis_reg;
    logic [TIME_W-1:0]      start_ms_reg;
    logic [TIME_W-1:0]      last_motion_reg;
    logic [ENERGY_W-1:0]    ea_reg;
    logic [ENERGY_W-1:0]    eg_reg;
    logic [ENERGY_W-1:0]    lim_reg;
    logic [ENERGY_W-1:0]    lim_next;
    logic                   out_valid_reg;
    msd_out_t               out_reg;

    logic [THR_W-1:0]       thr_reg;
    logic [TIME_W-1:0]      timeout_reg;
    logic [WIN_REG_W-1:0]   window_reg;
    logic [CNT_W-1:0]       win_len;

    logic signed [SAMPLE_W-1:0] samp_reg [NUM_AXES];
    logic [SUM_W-1:0]       sum_reg [NUM_AXES];
    logic                   carry_reg [NUM_AXES];
    logic                   sum_bit [NUM_AXES];
    logic                   carry_next [NUM_AXES];

    logic                   in_beat;
    logic                   out_free;
    logic [SUM_W-1:0]       sel_sum;
    logic [SUM_W-1:0]       sel_mag;
    logic                   axis_done;
    logic [ENERGY_W-1:0]    axis_square;
    logic                   still;
    logic [TIME_W-1:0]      elapsed;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= THRESHOLD_RST;
            timeout_reg <= TIMEOUT_RST;
            window_reg  <= WINDOW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STUCK_THRESHOLD: thr_reg     <= cfg_data[THR_W-1:0];
                CFG_TIMEOUT_MS:      timeout_reg <= cfg_data[TIME_W-1:0];
                CFG_WINDOW_SAMPLES:  window_reg  <= cfg_data[WIN_REG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // window length held between 1 and MAX_WINDOW
    always_comb
    begin
        if (window_reg == '0)
        begin
            win_len = CNT_W'(1);
        end
        else if (window_reg > WIN_REG_W'(MAX_WINDOW))
        begin
            win_len = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            win_len = CNT_W'(window_reg);
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_beat   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign count_inc = count_reg + CNT_W'(1);
    assign lim_next  = ENERGY_W'(thr_reg) * ENERGY_W'(thr_reg);

    // lsb-first serial add, the old sum is masked out for the first sample of a window
    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            sum_bit[k]    = (sum_reg[k][0] & !fresh_reg) ^ samp_reg[k][0] ^ carry_reg[k];
            carry_next[k] = ((sum_reg[k][0] & !fresh_reg) & samp_reg[k][0])
                          | ((sum_reg[k][0] & !fresh_reg) & carry_reg[k])
                          | (samp_reg[k][0] & carry_reg[k]);
        end
    end

    // averaging only needs the magnitude, the sign drops out in the square
    assign sel_sum = sum_reg[axis_reg];
    assign sel_mag = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : sel_sum;

    assign still   = (ea_reg < lim_reg) && (eg_reg < lim_reg);
    assign elapsed = start_ms_reg - last_motion_reg;

    msd_axis_unit #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_axis (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == ST_CLOSE_LOAD),
        .mag    (sel_mag),
        .len    (win_len),
        .done   (axis_done),
        .square (axis_square)
    );

    // sample shift registers and running sums
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            samp_reg[0] <= in_data.accel_x;
            samp_reg[1] <= in_data.accel_y;
            samp_reg[2] <= in_data.accel_z;
            samp_reg[3] <= in_data.gyro_x;
            samp_reg[4] <= in_data.gyro_y;
            samp_reg[5] <= in_data.gyro_z;
            for (int k = 0; k < NUM_AXES; k++)
            begin
                carry_reg[k] <= 1'b0;
            end
        end
        else if (state_reg == ST_ACCUM)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                // arithmetic shift keeps feeding the sign bit
                samp_reg[k]  <= samp_reg[k] >>> 1;
                sum_reg[k]   <= {sum_bit[k], sum_reg[k][SUM_W-1:1]};
                carry_reg[k] <= carry_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            bit_reg         <= '0;
            count_reg       <= '0;
            fresh_reg       <= 1'b0;
            axis_reg        <= '0;
            start_ms_reg    <= '0;
            last_motion_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // the finish step loads the next result beat itself
            if (out_valid_reg && !out_stall && state_reg != ST_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        state_reg <= ST_ACCUM;
                        bit_reg   <= '0;
                        fresh_reg <= (count_reg == '0);
                        if (count_reg == '0)
                        begin
                            start_ms_reg <= in_data.now_ms;
                        end
                    end
                end
                ST_ACCUM:
                begin
                    if (bit_reg == STEP_W'(SUM_W - 1))
                    begin
                        if (count_inc >= win_len)
                        begin
                            state_reg <= ST_CLOSE_LOAD;
                            count_reg <= '0;
                            axis_reg  <= '0;
                            ea_reg    <= '0;
                            eg_reg    <= '0;
                            lim_reg   <= lim_next;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                            count_reg <= count_inc;
                        end
                    end
                    else
                    begin
                        bit_reg <= bit_reg + STEP_W'(1);
                    end
                end
                ST_CLOSE_LOAD:
                begin
                    state_reg <= ST_CLOSE_WAIT;
                end
                ST_CLOSE_WAIT:
                begin
                    if (axis_done)
                    begin
                        if (axis_reg < GYRO_FIRST)
                        begin
                            ea_reg <= ea_reg + axis_square;
                        end
                        else
                        begin
                            eg_reg <= eg_reg + axis_square;
                        end
                        if (axis_reg == AXIS_LAST)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + AXIS_W'(1);
                            state_reg <= ST_CLOSE_LOAD;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg        <= 1'b1;
                        out_reg.stuck        <= still && (elapsed >= timeout_reg);
                        out_reg.accel_energy <= ea_reg;
                        out_reg.gyro_energy  <= eg_reg;
                        if (!still)
                        begin
                            last_motion_reg <= start_ms_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        axis_done |-> state_reg == ST_CLOSE_WAIT)
        else $error("axis unit finished outside the close phase");

    a_beat_starts_accum: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_ACCUM && bit_reg == '0)
        else $error("accepted sample did not start the serial add");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLOSE_LOAD |-> axis_reg <= AXIS_LAST)
        else $error("axis index out of range");

    a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_FINISH)
        else $error("result beat raised outside the finish step");

endmodule
